>>> rtl/xsk_pkg.sv
// ----------------------------------------------------------------------------
// XSalsa20 keystream package
// Shared types, constants and quarter-round index tables for the keystream
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xsk_pkg;

	localparam int NUM_CELLS = 10;

	localparam logic [2:0] PH_FIRST = 3'd0;

	localparam logic [6:0] BLOCK_BYTES = 7'd64;

	localparam logic [2:0] CFG_KEY_0   = 3'd0;
	localparam logic [2:0] CFG_KEY_1   = 3'd1;
	localparam logic [2:0] CFG_KEY_2   = 3'd2;
	localparam logic [2:0] CFG_KEY_3   = 3'd3;
	localparam logic [2:0] CFG_NONCE_0 = 3'd4;
	localparam logic [2:0] CFG_NONCE_1 = 3'd5;
	localparam logic [2:0] CFG_NONCE_2 = 3'd6;

	// "expand 32-byte k"
	localparam logic [31:0] SIGMA_0 = 32'h61707865;
	localparam logic [31:0] SIGMA_1 = 32'h3320646e;
	localparam logic [31:0] SIGMA_2 = 32'h79622d32;
	localparam logic [31:0] SIGMA_3 = 32'h6b206574;

	typedef logic [15:0][31:0] state_t;

	typedef struct packed {
		logic        op;
		logic [6:0]  byte_count;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] keystream_word;
		logic [2:0]  word_index;
		logic [3:0]  valid_bytes;
		logic        last;
	} out_beat_t;

	// Token that travels with a state through the chain.
	typedef struct packed {
		logic        valid;
		logic        derive;
		logic [6:0]  n;
		logic [63:0] ctr;
	} tag_t;

	// Word indices {a, b, c, d} of quarter q in a column or row round.
	function automatic logic [15:0] qr_idx(input logic row, input logic [1:0] q);
		logic [15:0] r;
		unique case ({row, q})
			3'b000: r = {4'd0, 4'd4, 4'd8, 4'd12};
			3'b001: r = {4'd5, 4'd9, 4'd13, 4'd1};
			3'b010: r = {4'd10, 4'd14, 4'd2, 4'd6};
			3'b011: r = {4'd15, 4'd3, 4'd7, 4'd11};
			3'b100: r = {4'd0, 4'd1, 4'd2, 4'd3};
			3'b101: r = {4'd5, 4'd6, 4'd7, 4'd4};
			3'b110: r = {4'd10, 4'd11, 4'd8, 4'd9};
			default: r = {4'd15, 4'd12, 4'd13, 4'd14};
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/xsk_cell.sv
// ----------------------------------------------------------------------------
// XSalsa20 double-round cell
// Holds one 512-bit state; one add-rotate-xor step per cycle while en is high;
// eight steps make a double round. At phase zero it takes its neighbor's state.
// ----------------------------------------------------------------------------
`default_nettype none

module xsk_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [2:0]      phase,
	input  xsk_pkg::state_t prev_state,
	input  xsk_pkg::tag_t   prev_tag,
	output xsk_pkg::state_t state,
	output xsk_pkg::tag_t   tag
);

	xsk_pkg::state_t state_q;
	xsk_pkg::tag_t   tag_q;
	xsk_pkg::state_t src;
	xsk_pkg::state_t nxt;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// One step: four independent quarters, each updating one word.
	function automatic xsk_pkg::state_t qr_step(input xsk_pkg::state_t w,
		input logic [2:0] ph);
		xsk_pkg::state_t r;
		logic [15:0]     ix;
		logic [3:0]      t;
		logic [3:0]      x;
		logic [3:0]      y;
		logic [31:0]     s;
		logic [31:0]     rs;
		r = w;
		for (int q = 0; q < 4; q++) begin
			ix = xsk_pkg::qr_idx(ph[2], 2'(q));
			unique case (ph[1:0])
				2'd0: begin
					t = ix[11:8]; x = ix[15:12]; y = ix[3:0];
				end
				2'd1: begin
					t = ix[7:4]; x = ix[11:8]; y = ix[15:12];
				end
				2'd2: begin
					t = ix[3:0]; x = ix[7:4]; y = ix[11:8];
				end
				default: begin
					t = ix[15:12]; x = ix[3:0]; y = ix[7:4];
				end
			endcase
			s = w[x] + w[y];
			unique case (ph[1:0])
				2'd0:    rs = rotl(s, 7);
				2'd1:    rs = rotl(s, 9);
				2'd2:    rs = rotl(s, 13);
				default: rs = rotl(s, 18);
			endcase
			r[t] = w[t] ^ rs;
		end
		return r;
	endfunction

	assign src = (phase == xsk_pkg::PH_FIRST) ? prev_state : state_q;
	assign nxt = qr_step(src, phase);

	always_ff @(posedge clk) begin
		if (en) begin
			state_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en && phase == xsk_pkg::PH_FIRST) begin
			tag_q <= prev_tag;
		end
	end

	assign state = state_q;
	assign tag   = tag_q;

endmodule

`default_nettype wire

>>> rtl/xsk_emit.sv
// ----------------------------------------------------------------------------
// XSalsa20 keystream word emitter
// Holds one finished block and sends it as 64-bit beats, masking the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module xsk_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  xsk_pkg::state_t    blk,
	input  logic [6:0]         n,
	output logic               free,
	output logic               out_valid,
	input  logic               out_ready,
	output xsk_pkg::out_beat_t out_data
);

	xsk_pkg::state_t blk_q;
	logic [6:0]      n_q;
	logic [2:0]      idx_q;
	logic            valid_q;
	logic [6:0]      nm1;
	logic [2:0]      words_m1;
	logic            last;
	logic [6:0]      rem;
	logic [3:0]      vb;
	logic [63:0]     word;
	logic [63:0]     masked;

	assign nm1      = n_q - 7'd1;
	assign words_m1 = nm1[5:3];
	assign last     = (idx_q == words_m1);
	assign rem      = n_q - {1'b0, idx_q, 3'b000};
	assign vb       = last ? rem[3:0] : 4'd8;
	assign word     = {blk_q[{idx_q, 1'b1}], blk_q[{idx_q, 1'b0}]};

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			masked[8*b +: 8] = (4'(b) < vb) ? word[8*b +: 8] : 8'h00;
		end
	end

	assign free      = !valid_q || (out_ready && last);
	assign out_valid = valid_q;

	always_comb begin
		out_data.keystream_word = masked;
		out_data.word_index     = idx_q;
		out_data.valid_bytes    = vb;
		out_data.last           = last;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			blk_q <= blk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
			n_q     <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
			n_q     <= n;
		end else if (valid_q && out_ready) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/xsalsa20_keystream_generator_core.sv
// ----------------------------------------------------------------------------
// XSalsa20 keystream generator core
// A restart's block waits until the subkey pass through the same chain
// has left it. A new 64-byte block can enter the chain at each phase-zero
// boundary, paced by the eight steps each double-round cell spends on a
// state; beats then leave one per cycle while out_ready is high.
// Reset: clears configuration, subkey, block counter and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module xsalsa20_keystream_generator_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  xsk_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output xsk_pkg::out_beat_t out_data,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_wdata
);

	// Configuration registers.
	logic [3:0][63:0]  key_q;
	logic [2:0][63:0]  nonce_q;

	// Cipher state outside the chain.
	logic [7:0][31:0]  subkey_q;
	logic [63:0]       ctr_q;
	logic              busy_q;     // subkey pass in flight
	logic [2:0]        phase_q;

	// Entry slot: one request waiting for the next injection boundary.
	logic              ent_valid_q;
	logic              ent_op_q;
	logic [6:0]        ent_n_q;

	logic              en;
	logic              boundary;
	logic              go;
	logic              inj_derive;
	logic              inj_block;
	logic              ent_free;
	logic              in_acc;
	logic [6:0]        n_sat;
	logic              emit_free;
	logic              emit_load;
	logic              sk_write;

	xsk_pkg::state_t   inj_state;
	xsk_pkg::tag_t     inj_tag;
	xsk_pkg::state_t   init_state;
	xsk_pkg::state_t   ff_state;

	xsk_pkg::state_t   cell_state [xsk_pkg::NUM_CELLS];
	xsk_pkg::tag_t     cell_tag   [xsk_pkg::NUM_CELLS];
	xsk_pkg::state_t   tail_state;
	xsk_pkg::tag_t     tail_tag;

	function automatic xsk_pkg::state_t load_state(input logic [7:0][31:0] k,
		input logic [3:0][31:0] m);
		xsk_pkg::state_t w;
		w[0]  = xsk_pkg::SIGMA_0;
		w[1]  = k[0]; w[2] = k[1]; w[3] = k[2]; w[4] = k[3];
		w[5]  = xsk_pkg::SIGMA_1;
		w[6]  = m[0]; w[7] = m[1]; w[8] = m[2]; w[9] = m[3];
		w[10] = xsk_pkg::SIGMA_2;
		w[11] = k[4]; w[12] = k[5]; w[13] = k[6]; w[14] = k[7];
		w[15] = xsk_pkg::SIGMA_3;
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Configuration writes; an index past the list is dropped.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			nonce_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				xsk_pkg::CFG_KEY_0:   key_q[0]   <= cfg_wdata;
				xsk_pkg::CFG_KEY_1:   key_q[1]   <= cfg_wdata;
				xsk_pkg::CFG_KEY_2:   key_q[2]   <= cfg_wdata;
				xsk_pkg::CFG_KEY_3:   key_q[3]   <= cfg_wdata;
				xsk_pkg::CFG_NONCE_0: nonce_q[0] <= cfg_wdata;
				xsk_pkg::CFG_NONCE_1: nonce_q[1] <= cfg_wdata;
				xsk_pkg::CFG_NONCE_2: nonce_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Chain control. All cells step together; at phase zero each cell
	// takes its neighbor's state, the head takes a fresh state and the
	// tail hands its finished state on. Freeze the whole chain only
	// when a finished block meets a full emitter.
	// ------------------------------------------------------------------
	assign tail_state = cell_state[xsk_pkg::NUM_CELLS-1];
	assign tail_tag   = cell_tag[xsk_pkg::NUM_CELLS-1];
	assign boundary   = (phase_q == xsk_pkg::PH_FIRST);

	assign en = !(boundary && tail_tag.valid && !tail_tag.derive && !emit_free);

	assign emit_load = en && boundary && tail_tag.valid && !tail_tag.derive;
	assign sk_write  = en && boundary && tail_tag.valid && tail_tag.derive;

	// Hold the entry while a subkey pass is in flight so the block sees
	// the new subkey.
	assign go         = en && boundary && ent_valid_q && !busy_q;
	assign inj_derive = go && ent_op_q;
	assign inj_block  = go && !ent_op_q && (ent_n_q != 7'd0);

	always_comb begin
		if (ent_op_q) begin
			inj_state = load_state(key_q, {nonce_q[1], nonce_q[0]});
		end else begin
			inj_state = load_state(subkey_q, {ctr_q, nonce_q[2]});
		end
		inj_tag.valid  = inj_derive || inj_block;
		inj_tag.derive = inj_derive;
		inj_tag.n      = ent_n_q;
		inj_tag.ctr    = ctr_q;
	end

	// ------------------------------------------------------------------
	// Input side: one entry slot, refilled in the cycle it drains.
	// ------------------------------------------------------------------
	assign ent_free = !ent_valid_q || (go && (!ent_op_q || ent_n_q == 7'd0));
	assign in_ready = ent_free;
	assign in_acc   = in_valid && ent_free;
	assign n_sat    = (in_data.byte_count > xsk_pkg::BLOCK_BYTES) ?
		xsk_pkg::BLOCK_BYTES : in_data.byte_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= 1'b0;
			ent_op_q    <= 1'b0;
			ent_n_q     <= '0;
		end else if (in_acc) begin
			ent_valid_q <= 1'b1;
			ent_op_q    <= in_data.op;
			ent_n_q     <= n_sat;
		end else if (go) begin
			if (ent_op_q && ent_n_q != 7'd0) begin
				// Subkey pass launched; keep the block part of the request.
				ent_op_q <= 1'b0;
			end else begin
				ent_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Block counter, subkey and phase.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q    <= '0;
			busy_q   <= 1'b0;
			subkey_q <= '0;
			phase_q  <= '0;
		end else begin
			if (en) begin
				phase_q <= phase_q + 3'd1;
			end
			if (inj_derive) begin
				ctr_q  <= '0;
				busy_q <= 1'b1;
			end else if (inj_block) begin
				ctr_q <= ctr_q + 64'd1;
			end
			if (sk_write) begin
				busy_q   <= 1'b0;
				// Keep words 0, 5, 10, 15, 6, 7, 8, 9; no feedforward.
				subkey_q <= {tail_state[9], tail_state[8], tail_state[7],
					tail_state[6], tail_state[15], tail_state[10],
					tail_state[5], tail_state[0]};
			end
		end
	end

	// ------------------------------------------------------------------
	// Cell chain: ten double-round cells.
	// ------------------------------------------------------------------
	for (genvar i = 0; i < xsk_pkg::NUM_CELLS; i++) begin : g_cell
		if (i == 0) begin : g_head
			xsk_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.en         (en),
				.phase      (phase_q),
				.prev_state (inj_state),
				.prev_tag   (inj_tag),
				.state      (cell_state[i]),
				.tag        (cell_tag[i])
			);
		end else begin : g_body
			xsk_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.en         (en),
				.phase      (phase_q),
				.prev_state (cell_state[i-1]),
				.prev_tag   (cell_tag[i-1]),
				.state      (cell_state[i]),
				.tag        (cell_tag[i])
			);
		end
	end

	// ------------------------------------------------------------------
	// Feedforward: rebuild the block's input from the subkey, the nonce
	// and the counter that traveled with it, then add word by word. The
	// subkey cannot change under a block still in the chain because a
	// subkey pass leaves the chain behind every block ahead of it.
	// ------------------------------------------------------------------
	assign init_state = load_state(subkey_q, {tail_tag.ctr, nonce_q[2]});

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			ff_state[i] = tail_state[i] + init_state[i];
		end
	end

	xsk_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (emit_load),
		.blk       (ff_state),
		.n         (tail_tag.n),
		.free      (emit_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

>>> dv/xsalsa20_keystream_generator_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// XSalsa20 keystream generator core testbench
// Drives restart and next-block requests through the valid/ready input port.
// Reprograms key and nonce while the core is idle. Every output beat is
// checked against a Salsa20/HSalsa20 predictor kept inside this bench.
// Pacing on both ports is random, and one long output stall fills the core.
// ----------------------------------------------------------------------------

module xsalsa20_keystream_generator_core_tb;

	// Request codes
	localparam logic OP_NEXT    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Register index past the end of the map; the core must ignore it
	localparam logic [2:0] CFG_NO_REG = 3'd7;

	localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

	// Marks a plan row whose beat count is left to the predictor
	localparam logic [3:0] BEATS_PREDICTED = 4'hf;

	localparam int DRAIN_CYCLES  = 300;     // restart pass plus block latency, with margin
	localparam int LONG_HOLD     = 600;     // output stall long enough to back up the chain
	localparam int ITEMS_PER_SUB = 29;
	localparam int CYCLE_LIMIT   = 400_000;

	typedef logic [15:0][31:0] salsa_words_t;

	typedef struct packed {
		logic        is_cfg;
		logic [2:0]  reg_idx;
		logic [63:0] wdata;
		logic        op;
		logic [6:0]  nbytes;
		logic [3:0]  beats;
	} plan_row_t;

	// Directed opening: reset subkey, byte-count extremes, all-ones key and
	// nonce, late config changes, and a write to the unused register slot.
	localparam int PLAN_LEN = 28;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd64,  4'd8},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd1,   4'd1},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd0,   4'd0},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd127, 4'd8},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd65,  4'd8},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_RESTART, 7'd0,   4'd0},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd63,  4'd8},
		'{1'b1, xsk_pkg::CFG_KEY_0,   ALL_ONES, OP_NEXT,    7'd0,   4'd0},
		'{1'b1, xsk_pkg::CFG_KEY_1,   ALL_ONES, OP_NEXT,    7'd0,   4'd0},
		'{1'b1, xsk_pkg::CFG_KEY_2,   ALL_ONES, OP_NEXT,    7'd0,   4'd0},
		'{1'b1, xsk_pkg::CFG_KEY_3,   ALL_ONES, OP_NEXT,    7'd0,   4'd0},
		'{1'b1, xsk_pkg::CFG_NONCE_0, ALL_ONES, OP_NEXT,    7'd0,   4'd0},
		'{1'b1, xsk_pkg::CFG_NONCE_1, ALL_ONES, OP_NEXT,    7'd0,   4'd0},
		'{1'b1, xsk_pkg::CFG_NONCE_2, ALL_ONES, OP_NEXT,    7'd0,   4'd0},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_RESTART, 7'd64,  4'd8},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd9,   4'd2},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd8,   4'd1},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd57,  4'd8},
		'{1'b1, xsk_pkg::CFG_NONCE_2, 64'd0,    OP_NEXT,    7'd0,   4'd0},
		'{1'b1, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd0,   4'd0},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd16,  4'd2},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_RESTART, 7'd0,   4'd0},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd33,  4'd5},
		'{1'b1, CFG_NO_REG,           ALL_ONES, OP_NEXT,    7'd0,   4'd0},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd64,  4'd8},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_RESTART, 7'd24,  4'd3},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd0,   4'd0},
		'{1'b0, xsk_pkg::CFG_KEY_0,   64'd0,    OP_NEXT,    7'd7,   4'd1}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	xsk_pkg::in_beat_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	xsk_pkg::out_beat_t out_data;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [63:0]        cfg_wdata = '0;

	// Bench copy of the core's programmable and internal state
	logic [63:0]       reg_shadow [7];
	logic [7:0][31:0]  subkey_now;
	logic [63:0]       block_ctr;

	// Keystream beats still owed by the core, oldest first
	xsk_pkg::out_beat_t keystream_due [$];

	int  tx_idle_pct = 0;
	int  rx_idle_pct = 0;
	int  hold_ask = 0;
	int  hold_taken = 0;
	int  hold_left = 0;
	int  cycles = 0;
	int  mismatches = 0;
	int  n_requests = 0;
	int  n_restarts = 0;
	int  n_empty = 0;
	int  n_oversized = 0;
	int  n_cfg_writes = 0;
	int  beats_checked = 0;
	bit  quiet = 1'b1;

	xsalsa20_keystream_generator_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Salsa20 predictor
	// ------------------------------------------------------------------

	function automatic logic [31:0] rotl(logic [31:0] v, int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// One quarter-round on words a, b, c, d
	function automatic salsa_words_t mix(salsa_words_t w, int a, int b, int c, int d);
		w[b] = w[b] ^ rotl(w[a] + w[d], 7);
		w[c] = w[c] ^ rotl(w[b] + w[a], 9);
		w[d] = w[d] ^ rotl(w[c] + w[b], 13);
		w[a] = w[a] ^ rotl(w[d] + w[c], 18);
		return w;
	endfunction

	// Ten double rounds: columns, then rows
	function automatic salsa_words_t salsa_rounds(salsa_words_t w);
		for (int r = 0; r < 10; r++) begin
			w = mix(w, 0, 4, 8, 12);
			w = mix(w, 5, 9, 13, 1);
			w = mix(w, 10, 14, 2, 6);
			w = mix(w, 15, 3, 7, 11);
			w = mix(w, 0, 1, 2, 3);
			w = mix(w, 5, 6, 7, 4);
			w = mix(w, 10, 11, 8, 9);
			w = mix(w, 15, 12, 13, 14);
		end
		return w;
	endfunction

	// Lay out constants, eight key words and four middle words
	function automatic salsa_words_t load_words(logic [7:0][31:0] k, logic [3:0][31:0] m);
		salsa_words_t w;
		w[0]  = xsk_pkg::SIGMA_0;
		w[5]  = xsk_pkg::SIGMA_1;
		w[10] = xsk_pkg::SIGMA_2;
		w[15] = xsk_pkg::SIGMA_3;
		for (int i = 0; i < 4; i++) begin
			w[1 + i]  = k[i];
			w[6 + i]  = m[i];
			w[11 + i] = k[4 + i];
		end
		return w;
	endfunction

	// HSalsa20 over the key and the first 16 nonce bytes; no feedforward
	function automatic void derive_subkey();
		logic [7:0][31:0] k;
		logic [3:0][31:0] m;
		salsa_words_t w;
		k = {reg_shadow[xsk_pkg::CFG_KEY_3], reg_shadow[xsk_pkg::CFG_KEY_2],
			reg_shadow[xsk_pkg::CFG_KEY_1], reg_shadow[xsk_pkg::CFG_KEY_0]};
		m = {reg_shadow[xsk_pkg::CFG_NONCE_1], reg_shadow[xsk_pkg::CFG_NONCE_0]};
		w = salsa_rounds(load_words(k, m));
		subkey_now = {w[9], w[8], w[7], w[6], w[15], w[10], w[5], w[0]};
	endfunction

	// Queue the beats one request should produce; return how many
	function automatic int predict_keystream_block(logic op, logic [6:0] nbytes);
		salsa_words_t init_w;
		salsa_words_t w;
		xsk_pkg::out_beat_t beat;
		int n;
		int words;
		int valid;
		if (op == OP_RESTART) begin
			derive_subkey();
			block_ctr = '0;
		end
		n = nbytes;
		if (n > xsk_pkg::BLOCK_BYTES)
			n = xsk_pkg::BLOCK_BYTES;
		if (n == 0)
			return 0;
		init_w = load_words(subkey_now, {block_ctr, reg_shadow[xsk_pkg::CFG_NONCE_2]});
		w = salsa_rounds(init_w);
		for (int i = 0; i < 16; i++)
			w[i] = w[i] + init_w[i];
		words = (n + 7) / 8;
		for (int k = 0; k < words; k++) begin
			beat.keystream_word = {w[2 * k + 1], w[2 * k]};
			valid = 8;
			if (k + 1 == words) begin
				valid = n - 8 * k;
				// zero the bytes past the end of the request
				if (valid < 8)
					beat.keystream_word &= (64'd1 << (8 * valid)) - 64'd1;
			end
			beat.word_index  = k[2:0];
			beat.valid_bytes = valid[3:0];
			beat.last        = (k + 1 == words);
			keystream_due.push_back(beat);
		end
		block_ctr = block_ctr + 64'd1;
		return words;
	endfunction

	// ------------------------------------------------------------------
	// Reporting and checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
		mismatches++;
		$display("mismatch at cycle %0d: %s expected %h got %h", cycles, what, want, got);
	endtask

	// Compare every accepted beat with the oldest owed one. Sample before the
	// edge's updates land, so the handshake seen here is the one the core saw.
	always @(posedge clk) begin : beat_check
		xsk_pkg::out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (keystream_due.size() == 0) begin
				report_mismatch("beat with nothing owed", '0, out_data.keystream_word);
			end else begin
				want = keystream_due.pop_front();
				beats_checked++;
				if (out_data.keystream_word !== want.keystream_word)
					report_mismatch("keystream_word", want.keystream_word,
						out_data.keystream_word);
				if (out_data.word_index !== want.word_index)
					report_mismatch("word_index", want.word_index, out_data.word_index);
				if (out_data.valid_bytes !== want.valid_bytes)
					report_mismatch("valid_bytes", want.valid_bytes, out_data.valid_bytes);
				if (out_data.last !== want.last)
					report_mismatch("last", want.last, out_data.last);
			end
		end
	end

	// Output side: random back-pressure, plus one long hold on request. A new
	// hold request restarts the count; while it runs, ready stays low.
	always @(posedge clk) begin
		if (hold_ask != hold_taken) begin
			hold_taken = hold_ask;
			hold_left  = LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left  = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d beats owed", cycles,
				keystream_due.size());
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers; each is entered just after a rising edge
	// ------------------------------------------------------------------

	// Drop valid, wait for every owed beat, then let the core finish any
	// restart or empty request that has no beat to show for it.
	task automatic settle();
		in_valid <= 1'b0;
		while (keystream_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		quiet = 1'b1;
	endtask

	// Write one register; the core must be idle, so settle first if needed
	task automatic write_reg(logic [2:0] idx, logic [63:0] data);
		if (!quiet)
			settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		if (idx <= xsk_pkg::CFG_NONCE_2)
			reg_shadow[idx] = data;
		n_cfg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Offer one request, holding valid and payload until the core takes it
	task automatic offer_request(logic op, logic [6:0] nbytes, logic [3:0] typed_beats);
		xsk_pkg::in_beat_t req;
		int produced;
		req.op = op;
		req.byte_count = nbytes;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		quiet = 1'b0;
		produced = predict_keystream_block(op, nbytes);
		n_requests++;
		if (op == OP_RESTART)
			n_restarts++;
		if (nbytes == 0)
			n_empty++;
		if (nbytes > xsk_pkg::BLOCK_BYTES)
			n_oversized++;
		// rows with a typed beat count cross-check the predictor's shape
		if (typed_beats != BEATS_PREDICTED && produced != typed_beats)
			report_mismatch("beats for directed request", typed_beats, produced);
	endtask

	// Register values weighted toward extremes and single-bit patterns
	function automatic logic [63:0] pick_reg_value();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return ALL_ONES;
			2: return 64'd1 << $urandom_range(0, 63);
			3: return ~(64'd1 << $urandom_range(0, 63));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Byte counts: mostly in range, some empty, some past the block size
	function automatic logic [6:0] pick_byte_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 7'd0;
		if (r < 25)
			return 7'($urandom_range(65, 127));
		if (r < 35)
			return 7'(8 * $urandom_range(1, 8));
		return 7'($urandom_range(1, 64));
	endfunction

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		plan_row_t row;
		logic op;
		bit restart_first;

		for (int i = 0; i < 7; i++)
			reg_shadow[i] = '0;
		subkey_now = '0;
		block_ctr  = '0;

		// Hold reset, then release on an edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// First pacing mode covers the directed opening too
		tx_idle_pct <= 25;
		rx_idle_pct <= 79;
		@(posedge clk);

		// Walk the directed plan; config rows wait for the core to go idle
		for (int i = 0; i < PLAN_LEN; i++) begin
			row = PLAN[i];
			if (row.is_cfg)
				write_reg(row.reg_idx, row.wdata);
			else
				offer_request(row.op, row.nbytes, row.beats);
		end

		// Random part: three pacing modes, four config settings in each
		for (int mode = 0; mode < 3; mode++) begin
			for (int sub = 0; sub < 4; sub++) begin
				settle();
				case (mode)
					0: begin
						tx_idle_pct <= 25;
						rx_idle_pct <= 79;
					end
					1: begin
						tx_idle_pct <= 79;
						rx_idle_pct <= 25;
					end
					default: begin
						tx_idle_pct <= 0;
						rx_idle_pct <= 0;
					end
				endcase
				@(posedge clk);

				// Rewrite the key and nonce; the first setting of each mode
				// touches every register
				for (int r = 0; r <= xsk_pkg::CFG_NONCE_2; r++)
					if (sub == 0 || $urandom_range(0, 9) < 7)
						write_reg(3'(r), pick_reg_value());
				if ($urandom_range(0, 7) == 0)
					write_reg(CFG_NO_REG, pick_reg_value());

				// Stall the output for a long stretch while requests keep
				// coming, so the chain fills and the input backs up
				if (mode == 2 && sub == 1)
					hold_ask <= hold_ask + 1;

				// Usually pick up the new key at once; sometimes run on with
				// the old subkey to see that only nonce_word_2 moves
				restart_first = ($urandom_range(0, 3) != 0);
				for (int it = 0; it < ITEMS_PER_SUB; it++) begin
					op = ((it == 0 && restart_first) || $urandom_range(0, 9) == 0)
						? OP_RESTART : OP_NEXT;
					offer_request(op, pick_byte_count(), BEATS_PREDICTED);
				end
			end
		end

		settle();

		$display("covered %0d requests: %0d restarts, %0d empty, %0d oversized; %0d reg writes",
			n_requests, n_restarts, n_empty, n_oversized, n_cfg_writes);
		$display("checked %0d keystream beats under three pacing modes and one long stall",
			beats_checked);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL");
		end
		$finish;
	end

endmodule
